@@ rtl/rdiv96_pkg.sv @@
// Package for the 96-bit restoring divider: beat payload types, command struct
// between controller and datapath, and sizing constants. No dependencies.
`default_nettype none

package rdiv96_pkg;

    localparam int WORD_BITS             = 32;
    localparam int MAX_BITS              = 96;
    localparam int MAGNITUDE_WORDS_DEF   = 3;

    typedef struct packed {
        logic [31:0] dividend_high;
        logic [63:0] dividend_low;
        logic [31:0] divisor_high;
        logic [63:0] divisor_low;
    } div_in_t;

    typedef struct packed {
        logic [63:0] quotient_low;
        logic [31:0] quotient_high;
        logic [63:0] remainder_low;
        logic [31:0] remainder_high;
        logic        divide_by_zero;
    } div_out_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
        logic capture;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ rtl/rdiv96_ctrl.sv @@
// Controller for the restoring divider: idle/run/done state machine, bit
// counter and result-beat valid. Depends on rdiv96_pkg.
`default_nettype none

module rdiv96_ctrl #(
    parameter int MAGNITUDE_WORDS = rdiv96_pkg::MAGNITUDE_WORDS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op_valid,
    output logic                     op_stall,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output rdiv96_pkg::dp_cmd_t      cmd
);
    import rdiv96_pkg::*;

    localparam int WIDTH = (WORD_BITS * MAGNITUDE_WORDS > MAX_BITS) ?
                           MAX_BITS : WORD_BITS * MAGNITUDE_WORDS;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               res_valid_reg, res_valid_next;
    logic               slot_free;

    assign op_stall  = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign slot_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(WIDTH - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                cmd.last = (cnt_reg == '0);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) |=> (state_reg == ST_RUN && cnt_reg == CNT_W'(WIDTH - 1)))
        else $error("accepted beat did not start a run");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cmd.last) |=> (state_reg == ST_DONE))
        else $error("last step did not end the run");

    a_capture_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (res_valid && !op_stall))
        else $error("captured result not presented");

endmodule

`default_nettype wire

@@ rtl/rdiv96_dp.sv @@
// Datapath for the restoring divider: operand, partial remainder and quotient
// shift registers, one subtract/compare per step, result register.
// Depends on rdiv96_pkg.
`default_nettype none

module rdiv96_dp #(
    parameter int MAGNITUDE_WORDS = rdiv96_pkg::MAGNITUDE_WORDS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rdiv96_pkg::dp_cmd_t cmd,
    input  wire rdiv96_pkg::div_in_t op_data,
    output rdiv96_pkg::div_out_t     res_data
);
    import rdiv96_pkg::*;

    localparam int WIDTH = (WORD_BITS * MAGNITUDE_WORDS > MAX_BITS) ?
                           MAX_BITS : WORD_BITS * MAGNITUDE_WORDS;

    logic [WIDTH-1:0]  dvd_reg, dvd_next;
    logic [WIDTH-1:0]  dvs_reg, dvs_next;
    logic [WIDTH-1:0]  quo_reg, quo_next;
    logic [WIDTH:0]    rem_reg, rem_next;
    logic              seen_reg, seen_next;
    logic              dz_reg, dz_next;
    div_out_t          res_reg, res_next;

    logic [MAX_BITS-1:0] num_full, den_full;
    logic [WIDTH-1:0]    num_in, den_in;
    logic [WIDTH:0]      rem_shift;
    logic [WIDTH+1:0]    diff;
    logic                seen_now;
    logic                qbit;
    logic [MAX_BITS-1:0] quo_wide, rem_wide;

    assign num_full = {op_data.dividend_high, op_data.dividend_low};
    assign den_full = {op_data.divisor_high, op_data.divisor_low};
    assign num_in   = num_full[WIDTH-1:0];
    assign den_in   = den_full[WIDTH-1:0];

    // shift in next dividend bit, trial subtract
    assign rem_shift = {rem_reg[WIDTH-1:0], dvd_reg[WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign seen_now  = seen_reg | dvd_reg[WIDTH-1];
    // zero divisor: leading zeros of the dividend give no quotient bit
    assign qbit      = !diff[WIDTH+1] && (seen_now || cmd.last);

    assign quo_wide = MAX_BITS'(quo_reg);
    assign rem_wide = MAX_BITS'(rem_reg[WIDTH-1:0]);

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        seen_next = seen_reg;
        dz_next   = dz_reg;
        res_next  = res_reg;
        if (cmd.load)
        begin
            dvd_next  = num_in;
            dvs_next  = den_in;
            quo_next  = '0;
            rem_next  = '0;
            seen_next = 1'b0;
            dz_next   = (den_in == '0);
        end
        else if (cmd.step)
        begin
            dvd_next  = {dvd_reg[WIDTH-2:0], 1'b0};
            quo_next  = {quo_reg[WIDTH-2:0], qbit};
            rem_next  = qbit ? diff[WIDTH:0] : rem_shift;
            seen_next = seen_now;
        end
        if (cmd.capture)
        begin
            res_next.quotient_low   = quo_wide[63:0];
            res_next.quotient_high  = quo_wide[95:64];
            res_next.remainder_low  = rem_wide[63:0];
            res_next.remainder_high = rem_wide[95:64];
            res_next.divide_by_zero = dz_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        seen_reg <= seen_next;
        dz_reg   <= dz_next;
        res_reg  <= res_next;
    end

    assign res_data = res_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !dz_reg) |=> (rem_reg < {1'b0, dvs_reg}))
        else $error("partial remainder not reduced below divisor");

    a_capture_dz: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (res_data.divide_by_zero == (dvs_reg == '0)))
        else $error("divide-by-zero flag disagrees with held divisor");

endmodule

`default_nettype wire

@@ rtl/restoring_divider_96bit.sv @@
// Unsigned 96-bit restoring divider: one quotient bit per cycle.
// Flow: an operand beat is loaded in idle, then one step per bit through the subtractor,
// WIDTH = 32 * MAGNITUDE_WORDS capped at 96, then capture into the output register once free.
// A new operand beat is taken only in idle, after the last result is captured; it is
// taken while a finished result still waits in the output register.
// Reset (rst_n, async low) clears state machine, counter and result valid only.
`default_nettype none

module restoring_divider_96bit #(
    parameter int MAGNITUDE_WORDS = rdiv96_pkg::MAGNITUDE_WORDS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 op_valid,
    output logic                      op_stall,
    input  wire rdiv96_pkg::div_in_t  op_data,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output rdiv96_pkg::div_out_t      res_data
);
    import rdiv96_pkg::*;

    dp_cmd_t cmd;

    rdiv96_ctrl #(
        .MAGNITUDE_WORDS (MAGNITUDE_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    rdiv96_dp #(
        .MAGNITUDE_WORDS (MAGNITUDE_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .op_data  (op_data),
        .res_data (res_data)
    );

endmodule

`default_nettype wire

@@ tb/div96_result_checker.sv @@
// Checker for the 96-bit restoring divider: watches both channels, predicts each
// result from the operand beat and compares field by field. Depends on rdiv96_pkg.
`timescale 1ns / 1ps

module div96_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  logic                op_stall,
    input  rdiv96_pkg::div_in_t  op_data,
    input  logic                res_valid,
    input  logic                res_stall,
    input  rdiv96_pkg::div_out_t res_data,
    output int                  errors,
    output int                  pending
);
    import rdiv96_pkg::*;

    localparam int OPERAND_BITS = (WORD_BITS * MAGNITUDE_WORDS_DEF > MAX_BITS)
                                  ? MAX_BITS : WORD_BITS * MAGNITUDE_WORDS_DEF;
    localparam logic [95:0] OPERAND_MASK = {96{1'b1}} >> (96 - OPERAND_BITS);

    div_out_t predicted_results[$];

    initial errors = 0;
    initial pending = 0;

    task automatic report_mismatch(string detail);
        $display("[%0t] mismatch: %s", $realtime, detail);
        errors++;
    endtask

    // Restoring division over a 97-bit partial remainder, walked from the
    // dividend's top set bit down to bit 0 (bit 0 alone for a zero dividend).
    function automatic div_out_t divide_96(div_in_t beat);
        logic [95:0] num;
        logic [95:0] den;
        logic [95:0] quo;
        logic [96:0] rem;
        int          top;
        int          i;
        div_out_t    r;
        num = {beat.dividend_high, beat.dividend_low} & OPERAND_MASK;
        den = {beat.divisor_high, beat.divisor_low} & OPERAND_MASK;
        top = 0;
        for (i = 0; i < 96; i++)
            if (num[i])
                top = i;
        rem = '0;
        quo = '0;
        for (i = top; i >= 0; i--)
        begin
            rem = {rem[95:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        r.quotient_low   = quo[63:0];
        r.quotient_high  = quo[95:64];
        r.remainder_low  = rem[63:0];
        r.remainder_high = rem[95:64];
        r.divide_by_zero = (den == '0);
        return r;
    endfunction

    always @(posedge clk)
    begin
        div_out_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch($sformatf("unexpected result beat %h", res_data));
                else
                begin
                    want = predicted_results.pop_front();
                    if (res_data.quotient_low !== want.quotient_low)
                        report_mismatch($sformatf("quotient_low got %h want %h",
                                                  res_data.quotient_low, want.quotient_low));
                    if (res_data.quotient_high !== want.quotient_high)
                        report_mismatch($sformatf("quotient_high got %h want %h",
                                                  res_data.quotient_high, want.quotient_high));
                    if (res_data.remainder_low !== want.remainder_low)
                        report_mismatch($sformatf("remainder_low got %h want %h",
                                                  res_data.remainder_low, want.remainder_low));
                    if (res_data.remainder_high !== want.remainder_high)
                        report_mismatch($sformatf("remainder_high got %h want %h",
                                                  res_data.remainder_high,
                                                  want.remainder_high));
                    if (res_data.divide_by_zero !== want.divide_by_zero)
                        report_mismatch($sformatf("divide_by_zero got %b want %b",
                                                  res_data.divide_by_zero,
                                                  want.divide_by_zero));
                end
            end
            if (op_valid && !op_stall)
                predicted_results.push_back(divide_96(op_data));
            pending <= predicted_results.size();
        end
    end

endmodule

@@ tb/tb_restoring_divider_96bit.sv @@
// Top of the 96-bit restoring divider testbench: clock, reset, operand stimulus,
// result-side stall pattern, watchdog and verdict. Depends on rdiv96_pkg, the
// divider RTL and div96_result_checker.
`timescale 1ns / 1ps

module tb_restoring_divider_96bit;
    import rdiv96_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_BEATS = 1650;
    localparam int DRAIN_CYCLES = 300;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

    logic     clk;
    logic     rst_n;
    logic     op_valid;
    logic     op_stall;
    div_in_t  op_data;
    logic     res_valid;
    logic     res_stall = 1'b0;
    div_out_t res_data;
    int       errors;
    int       pending;
    int       idle_cycles = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;

    restoring_divider_96bit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    div96_result_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result-side backpressure, switching pattern at random intervals
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(100, 800);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            STALL_NONE:  res_stall <= 1'b0;
            STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
            default:
            begin
                if (run_left == 0)
                begin
                    res_stall <= ~res_stall;
                    run_left  <= $urandom_range(1, 40);
                end
                else
                    run_left <= run_left - 1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (op_valid && !op_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("restoring_divider_96bit verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [95:0] rand_operand(int len);
        logic [95:0] v;
        v = {$urandom, $urandom, $urandom};
        return v & ({96{1'b1}} >> (96 - len));
    endfunction

    // drive one operand beat and hold it until taken; valid stays high after
    task automatic send_operands(logic [95:0] num, logic [95:0] den);
        div_in_t beat;
        beat.dividend_low  = num[63:0];
        beat.dividend_high = num[95:64];
        beat.divisor_low   = den[63:0];
        beat.divisor_high  = den[95:64];
        op_valid <= 1'b1;
        op_data  <= beat;
        do
            @(posedge clk);
        while (op_stall);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [95:0] num;
        logic [95:0] den;
        logic [95:0] ones;
        int          n;
        int          pick;
        int          burst_left;
        int          gap;
        ones     = {96{1'b1}};
        rst_n    = 1'b0;
        op_valid <= 1'b0;
        op_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, zero operands, carries across the word split
        send_operands('0, '0);
        send_operands('0, 96'd1);
        send_operands('0, ones);
        send_operands(96'd1, '0);
        send_operands(ones, '0);
        send_operands(96'd1 << 95, '0);
        send_operands(ones, 96'd1);
        send_operands(ones, ones);
        send_operands(96'd1, ones);
        send_operands(ones, 96'd2);
        send_operands(96'd1, 96'd1);
        send_operands(96'd1 << 95, 96'd1);
        send_operands({32'hFFFF_FFFF, 64'h0}, {32'h1, 64'h0});
        send_operands(96'd1 << 63, 96'd3);
        send_operands(96'd5, 96'd7);
        send_operands({32'h0, {64{1'b1}}}, 96'd1 << 64);
        send_operands(ones, 96'd1 << 95);
        send_operands({32'h0, {64{1'b1}}}, {32'hFFFF_FFFF, 64'h0});
        send_operands({24{4'hA}}, {24{4'h5}});
        send_operands({24{4'h5}}, {24{4'hA}});
        send_operands(ones - 1, ones);
        send_operands(96'd1 << 64, {32'h0, {64{1'b1}}});
        op_valid <= 1'b0;
        wait_drained();

        burst_left = $urandom_range(1, 12);
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                num = rand_operand(96);
                den = rand_operand(96);
            end
            else if (pick < 55)
            begin
                num = rand_operand($urandom_range(1, 96));
                den = rand_operand($urandom_range(1, 96));
            end
            else if (pick < 65)
            begin
                num = rand_operand($urandom_range(1, 96));
                den = rand_operand($urandom_range(1, 8));
            end
            else if (pick < 72)
            begin
                num = ($urandom_range(0, 9) == 0) ? '0 : rand_operand($urandom_range(1, 96));
                den = '0;
            end
            else if (pick < 80)
            begin
                den = rand_operand($urandom_range(2, 96));
                num = den >> $urandom_range(1, 20);
            end
            else if (pick < 86)
            begin
                den = rand_operand($urandom_range(1, 96));
                case ($urandom_range(0, 2))
                    0: num = den;
                    1: num = den + 1;
                    default: num = den - 1;
                endcase
            end
            else if (pick < 92)
            begin
                num = '0;
                den = rand_operand($urandom_range(1, 96));
            end
            else
            begin
                num = 96'd1 << $urandom_range(0, 95);
                den = 96'd1 << $urandom_range(0, 95);
            end
            send_operands(num, den);

            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 39) == 0)
                begin
                    op_valid <= 1'b0;
                    wait_drained();
                end
                else if ($urandom_range(0, 2) != 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                      : $urandom_range(1, 15);
                    op_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        op_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("restoring_divider_96bit verification clean");
        else
            $display("restoring_divider_96bit verification failed");
        $finish;
    end

endmodule
